// File: src/uniform_grid_cell_index_macros.svh
// Assertion macros used by the checker file of the grid cell index block.
`ifndef UNIFORM_GRID_CELL_INDEX_MACROS_SVH
`define UNIFORM_GRID_CELL_INDEX_MACROS_SVH

// Same-cycle implication.
`define UGCI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid cell index check failed");

// Implication in the next cycle.
`define UGCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid cell index check failed");

// Implication after a fixed number of cycles.
`define UGCI_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("grid cell index check failed");

`endif

// File: src/ugci_pkg.sv
// Package with the types, constants and helper functions of the grid cell index block.
package ugci_pkg;

  localparam int IDX_W = 30;
  localparam int POS_W = 32;
  localparam int SIZE_W = 31;
  localparam int OFS_W = 31;
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_CELLS_PER_AXIS = 1024;

  localparam logic [POS_W-1:0] RESET_MAX = 32'd65536;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 31'd65536;
  localparam logic [OFS_W-1:0] OFS_SAT = {OFS_W{1'b1}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_X,
    REG_MIN_Y,
    REG_MIN_Z,
    REG_MAX_X,
    REG_MAX_Y,
    REG_MAX_Z,
    REG_CELL_SIZE
  } reg_index_t;

  typedef struct packed {
    logic mode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0] query_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic inside_range;
    logic in_grid;
    logic [OFS_W-1:0] offset_x;
    logic [OFS_W-1:0] offset_y;
    logic [OFS_W-1:0] offset_z;
  } result_t;

  typedef struct packed {
    logic signed [POS_W-1:0] min_x;
    logic signed [POS_W-1:0] min_y;
    logic signed [POS_W-1:0] min_z;
    logic signed [POS_W-1:0] max_x;
    logic signed [POS_W-1:0] max_y;
    logic signed [POS_W-1:0] max_z;
    logic [SIZE_W-1:0] cell_size;
  } bounds_t;

  typedef struct packed {
    logic mode;
    logic in_range;
    logic [2:0] neg;
    logic q_below_total;
    logic layer_zero;
  } side_t;

  function automatic int count_width(input int max_cells);
    return $clog2(max_cells + 1);
  endfunction

  function automatic int pipe_latency(input int max_cells);
    return IDX_W + 5 + count_width(max_cells);
  endfunction

endpackage

// File: src/ugci_divider.sv
// Pipelined restoring divider with several lanes, one quotient bit per stage.
module ugci_divider #(
  parameter int LANES = 1,
  parameter int DW = 32,
  parameter int VW = 31,
  parameter int QW = 30,
  parameter int SW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [LANES-1:0][DW-1:0]     dividend,
  input  logic [LANES-1:0][VW-1:0]     divisor,
  input  logic [SW-1:0]                side_in,
  output logic                         out_valid,
  output logic [LANES-1:0][QW-1:0]     quotient,
  output logic [LANES-1:0][DW-1:0]     remainder,
  output logic [LANES-1:0]             overflow,
  output logic [SW-1:0]                side_out
);

  localparam int WW = (VW + QW > DW) ? VW + QW : DW;
  localparam int NS = QW + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0][LANES-1:0][DW-1:0] rem, rem_next;
  logic [NS-1:0][LANES-1:0][VW-1:0] dvs, dvs_next;
  logic [NS-1:0][LANES-1:0][QW-1:0] quo, quo_next;
  logic [NS-1:0][LANES-1:0] ovf, ovf_next;
  logic [NS-1:0][SW-1:0] side, side_next;
  logic [WW-1:0] trial;

  always_comb begin
    trial = '0;
    side_next[0] = side_in;
    for (int l = 0; l < LANES; l++) begin
      rem_next[0][l] = dividend[l];
      dvs_next[0][l] = divisor[l];
      quo_next[0][l] = '0;
      ovf_next[0][l] = ((WW+1)'(dividend[l]) >= ((WW+1)'(divisor[l]) << QW));
    end
    for (int k = 1; k < NS; k++) begin
      side_next[k] = side[k-1];
      for (int l = 0; l < LANES; l++) begin
        trial = WW'(dvs[k-1][l]) << (QW - k);
        dvs_next[k][l] = dvs[k-1][l];
        ovf_next[k][l] = ovf[k-1][l];
        quo_next[k][l] = quo[k-1][l];
        rem_next[k][l] = rem[k-1][l];
        if (WW'(rem[k-1][l]) >= trial) begin
          rem_next[k][l] = DW'(WW'(rem[k-1][l]) - trial);
          quo_next[k][l][QW-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], in_valid};
    end
    rem <= rem_next;
    dvs <= dvs_next;
    quo <= quo_next;
    ovf <= ovf_next;
    side <= side_next;
  end

  assign out_valid = vld[NS-1];
  assign quotient = quo[NS-1];
  assign remainder = rem[NS-1];
  assign overflow = ovf[NS-1];
  assign side_out = side[NS-1];

endmodule

// File: src/ugci_cfg.sv
// Configuration registers and the per-axis cell count recompute.
module ugci_cfg #(
  parameter int MAX_CELLS_PER_AXIS = ugci_pkg::MAX_CELLS_PER_AXIS,
  localparam int CW = ugci_pkg::count_width(MAX_CELLS_PER_AXIS),
  localparam int LW = 2 * CW,
  localparam int TW = 3 * CW
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic [ugci_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [ugci_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ugci_pkg::bounds_t                   bounds,
  output logic [2:0][CW-1:0]                  count,
  output logic [LW-1:0]                       layer,
  output logic [TW-1:0]                       total,
  output logic                                busy
);

  localparam int BUSY_CYCLES = CW + 5;
  localparam int BW = $clog2(BUSY_CYCLES + 1);

  ugci_pkg::bounds_t grid;
  logic launch;
  logic [BW-1:0] busy_cnt;
  logic wr_known;
  logic [2:0][32:0] span;
  logic [2:0][31:0] cdiv_dividend;
  logic [2:0][ugci_pkg::SIZE_W-1:0] cdiv_divisor;
  logic cdiv_valid;
  logic [2:0][CW-1:0] cdiv_quo;
  logic [2:0][31:0] cdiv_rem;
  logic [2:0] cdiv_ovf;

  assign wr_known = cfg_wr && (cfg_index <= ugci_pkg::REG_CELL_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid.min_x <= '0;
      grid.min_y <= '0;
      grid.min_z <= '0;
      grid.max_x <= ugci_pkg::RESET_MAX;
      grid.max_y <= ugci_pkg::RESET_MAX;
      grid.max_z <= ugci_pkg::RESET_MAX;
      grid.cell_size <= ugci_pkg::RESET_SIZE;
      launch <= 1'b0;
      busy_cnt <= '0;
    end else begin
      launch <= wr_known;
      if (wr_known) begin
        busy_cnt <= BW'(BUSY_CYCLES);
      end else if (busy_cnt != '0) begin
        busy_cnt <= busy_cnt - 1'b1;
      end
      if (cfg_wr) begin
        unique case (ugci_pkg::reg_index_t'(cfg_index))
          ugci_pkg::REG_MIN_X: grid.min_x <= cfg_data;
          ugci_pkg::REG_MIN_Y: grid.min_y <= cfg_data;
          ugci_pkg::REG_MIN_Z: grid.min_z <= cfg_data;
          ugci_pkg::REG_MAX_X: grid.max_x <= cfg_data;
          ugci_pkg::REG_MAX_Y: grid.max_y <= cfg_data;
          ugci_pkg::REG_MAX_Z: grid.max_z <= cfg_data;
          ugci_pkg::REG_CELL_SIZE: grid.cell_size <= cfg_data[ugci_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    bounds = grid;
    if (grid.cell_size == '0) begin
      bounds.cell_size = ugci_pkg::SIZE_W'(1);
    end
  end

  assign span[0] = {grid.max_x[31], grid.max_x} - {grid.min_x[31], grid.min_x};
  assign span[1] = {grid.max_y[31], grid.max_y} - {grid.min_y[31], grid.min_y};
  assign span[2] = {grid.max_z[31], grid.max_z} - {grid.min_z[31], grid.min_z};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cdiv_dividend[l] = span[l][32] ? '0 : span[l][31:0];
      cdiv_divisor[l] = bounds.cell_size;
    end
  end

  ugci_divider #(
    .LANES(3),
    .DW(32),
    .VW(ugci_pkg::SIZE_W),
    .QW(CW),
    .SW(1)
  ) u_count_div (
    .clk(clk),
    .rst(rst),
    .in_valid(launch),
    .dividend(cdiv_dividend),
    .divisor(cdiv_divisor),
    .side_in(1'b0),
    .out_valid(cdiv_valid),
    .quotient(cdiv_quo),
    .remainder(cdiv_rem),
    .overflow(cdiv_ovf),
    .side_out()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      layer <= '0;
      total <= '0;
    end else begin
      if (cdiv_valid) begin
        for (int l = 0; l < 3; l++) begin
          if (cdiv_ovf[l] || (cdiv_quo[l] > CW'(MAX_CELLS_PER_AXIS))) begin
            count[l] <= CW'(MAX_CELLS_PER_AXIS);
          end else begin
            count[l] <= cdiv_quo[l];
          end
        end
      end
      layer <= LW'(count[0]) * LW'(count[1]);
      total <= TW'(layer) * TW'(count[2]);
    end
  end

  assign busy = (busy_cnt != '0);

endmodule

// File: src/uniform_grid_cell_index.sv
// Top level of the uniform grid cell index block.
//
//   channel   signals                                  direction
//   command   start, busy, item                        in (busy out)
//   result    done, result                             out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// A new item may be started in every cycle while busy is low; results cannot be held off.
// Each result appears with done after the input register, the 31-stage index divider,
// the row divider, the product register and the output register; the index divider is the longest part.
// A write to a known register holds busy high while the cell counts are recomputed
// through a divider pipeline.
// Reset clears the pipeline valid bits and the counts and loads the register defaults.
module uniform_grid_cell_index #(
  parameter int MAX_CELLS_PER_AXIS = ugci_pkg::MAX_CELLS_PER_AXIS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ugci_pkg::in_item_t                 item,
  output logic                               done,
  output ugci_pkg::result_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ugci_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [ugci_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = ugci_pkg::count_width(MAX_CELLS_PER_AXIS);
  localparam int LW = 2 * CW;
  localparam int TW = 3 * CW;
  localparam int IW = ugci_pkg::IDX_W;
  localparam int VW = (LW > ugci_pkg::SIZE_W) ? LW : ugci_pkg::SIZE_W;
  localparam int OPW = IW + ugci_pkg::SIZE_W;
  localparam int CMPW = (TW > IW) ? TW : IW;

  typedef struct packed {
    ugci_pkg::side_t side;
    logic ok;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [IW-1:0] cz;
  } mid_t;

  ugci_pkg::bounds_t bounds;
  logic [2:0][CW-1:0] count;
  logic [LW-1:0] layer;
  logic [TW-1:0] total;

  logic a_vld;
  ugci_pkg::in_item_t a_item;
  logic [2:0][31:0] pos_arr, min_arr, max_arr;
  logic [2:0][32:0] rel;
  logic [2:0] in_axis;
  ugci_pkg::side_t side_a;
  logic [2:0][31:0] diva_dividend;
  logic [2:0][VW-1:0] diva_divisor;

  logic diva_valid;
  logic [2:0][IW-1:0] diva_quo;
  logic [2:0][31:0] diva_rem;
  logic [2:0] diva_ovf;
  logic [$bits(ugci_pkg::side_t)-1:0] diva_side;
  ugci_pkg::side_t side_b;
  logic [2:0] ok_axis;
  mid_t mid_a, mid_b;
  logic [0:0][LW-1:0] divb_dividend;
  logic [0:0][CW-1:0] divb_divisor;
  logic divb_valid;
  logic [0:0][CW-1:0] divb_quo;
  logic [0:0][LW-1:0] divb_rem;
  logic [0:0] divb_ovf;
  logic [$bits(mid_t)-1:0] divb_side;
  logic [CW-1:0] cell_x, cell_y;
  logic [IW-1:0] cell_z;

  logic m_vld, m_mode, m_ok, m_inside, m_qlt;
  logic [CW-1:0] m_cx;
  logic [IW-1:0] m_p1, m_p2;
  logic [OPW-1:0] m_ox, m_oy, m_oz;
  ugci_pkg::result_t result_next;

  assign cfg_ready = 1'b1;

  ugci_cfg #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_wr(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .bounds(bounds),
    .count(count),
    .layer(layer),
    .total(total),
    .busy(busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
    a_item <= item;
  end

  assign pos_arr = {a_item.pos_z, a_item.pos_y, a_item.pos_x};
  assign min_arr = {bounds.min_z, bounds.min_y, bounds.min_x};
  assign max_arr = {bounds.max_z, bounds.max_y, bounds.max_x};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rel[l] = {pos_arr[l][31], pos_arr[l]} - {min_arr[l][31], min_arr[l]};
      in_axis[l] = ($signed(min_arr[l]) < $signed(pos_arr[l])) &&
                   ($signed(pos_arr[l]) < $signed(max_arr[l]));
      diva_dividend[l] = rel[l][32] ? '0 : rel[l][31:0];
      diva_divisor[l] = VW'(bounds.cell_size);
    end
    if (a_item.mode) begin
      diva_dividend[0] = 32'(a_item.query_index);
      diva_divisor[0] = VW'(layer);
    end
    side_a.mode = a_item.mode;
    side_a.in_range = &in_axis;
    side_a.neg = {rel[2][32], rel[1][32], rel[0][32]};
    side_a.q_below_total = (CMPW'(a_item.query_index) < CMPW'(total));
    side_a.layer_zero = (layer == '0);
  end

  ugci_divider #(
    .LANES(3),
    .DW(32),
    .VW(VW),
    .QW(IW),
    .SW($bits(ugci_pkg::side_t))
  ) u_index_div (
    .clk(clk),
    .rst(rst),
    .in_valid(a_vld),
    .dividend(diva_dividend),
    .divisor(diva_divisor),
    .side_in(side_a),
    .out_valid(diva_valid),
    .quotient(diva_quo),
    .remainder(diva_rem),
    .overflow(diva_ovf),
    .side_out(diva_side)
  );

  assign side_b = diva_side;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ok_axis[l] = !side_b.neg[l] && !diva_ovf[l] && (diva_quo[l] < IW'(count[l]));
    end
    mid_a.side = side_b;
    mid_a.ok = &ok_axis;
    mid_a.cx = diva_quo[0][CW-1:0];
    mid_a.cy = diva_quo[1][CW-1:0];
    mid_a.cz = side_b.mode ? diva_quo[0] : diva_quo[2];
    divb_dividend[0] = LW'(diva_rem[0]);
    divb_divisor[0] = count[0];
  end

  ugci_divider #(
    .LANES(1),
    .DW(LW),
    .VW(CW),
    .QW(CW),
    .SW($bits(mid_t))
  ) u_row_div (
    .clk(clk),
    .rst(rst),
    .in_valid(diva_valid),
    .dividend(divb_dividend),
    .divisor(divb_divisor),
    .side_in(mid_a),
    .out_valid(divb_valid),
    .quotient(divb_quo),
    .remainder(divb_rem),
    .overflow(divb_ovf),
    .side_out(divb_side)
  );

  assign mid_b = divb_side;

  always_comb begin
    if (mid_b.side.layer_zero) begin
      cell_x = '0;
      cell_y = '0;
      cell_z = '0;
    end else begin
      cell_x = divb_rem[0][CW-1:0];
      cell_y = divb_quo[0];
      cell_z = mid_b.cz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= divb_valid;
    end
    m_mode <= mid_b.side.mode;
    m_ok <= mid_b.ok;
    m_inside <= mid_b.side.in_range;
    m_qlt <= mid_b.side.q_below_total;
    m_cx <= mid_b.cx;
    m_p1 <= IW'(count[0]) * IW'(mid_b.cy);
    m_p2 <= IW'(layer) * mid_b.cz;
    m_ox <= OPW'(cell_x) * OPW'(bounds.cell_size);
    m_oy <= OPW'(cell_y) * OPW'(bounds.cell_size);
    m_oz <= OPW'(cell_z) * OPW'(bounds.cell_size);
  end

  always_comb begin
    result_next = '0;
    if (m_mode) begin
      result_next.in_grid = m_qlt;
      result_next.offset_x = (m_ox > OPW'(ugci_pkg::OFS_SAT)) ? ugci_pkg::OFS_SAT :
                             m_ox[ugci_pkg::OFS_W-1:0];
      result_next.offset_y = (m_oy > OPW'(ugci_pkg::OFS_SAT)) ? ugci_pkg::OFS_SAT :
                             m_oy[ugci_pkg::OFS_W-1:0];
      result_next.offset_z = (m_oz > OPW'(ugci_pkg::OFS_SAT)) ? ugci_pkg::OFS_SAT :
                             m_oz[ugci_pkg::OFS_W-1:0];
    end else begin
      result_next.inside_range = m_inside;
      result_next.in_grid = m_ok;
      if (m_ok) begin
        result_next.cell_index = IW'(m_cx) + m_p1 + m_p2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
    result <= result_next;
  end

endmodule

// File: src/ugci_checker.sv
// Port-level checker for the grid cell index block and its bind.
`include "uniform_grid_cell_index_macros.svh"

module ugci_checker #(
  parameter int MAX_CELLS_PER_AXIS = ugci_pkg::MAX_CELLS_PER_AXIS
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input ugci_pkg::in_item_t                 item,
  input logic                               done,
  input ugci_pkg::result_t                  result,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [ugci_pkg::REG_IDX_W-1:0]     cfg_index,
  input logic [ugci_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LAT = ugci_pkg::pipe_latency(MAX_CELLS_PER_AXIS);

  `UGCI_ASSERT_DELAY(a_beat_latency, clk, rst, start && !busy, LAT, done)
  `UGCI_ASSERT_IMPL(a_no_orphan, clk, rst, done, $past(start && !busy && !rst, LAT))
  `UGCI_ASSERT_NEXT(a_cfg_busy, clk, rst, cfg_valid && cfg_ready && (cfg_index <= ugci_pkg::REG_CELL_SIZE), busy)
  `UGCI_ASSERT_IMPL(a_mode_split, clk, rst, done && ((result.offset_x != '0) || (result.offset_y != '0) || (result.offset_z != '0)), (result.cell_index == '0) && !result.inside_range)

endmodule

bind uniform_grid_cell_index ugci_checker #(
  .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
) u_checker (.*);

// File: test/uniform_grid_cell_index_test.sv
// Testbench for the uniform grid cell index block: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module uniform_grid_cell_index_test;
  import ugci_pkg::*;

  localparam logic MODE_POS = 1'b0;
  localparam logic MODE_INDEX = 1'b1;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN = pipe_latency(MAX_CELLS_PER_AXIS) + 20;
  localparam int LIMIT = 400000;
  localparam int N_RANDOM = 490;

  class grid_scoreboard;
    longint lo[3];
    longint hi[3];
    longint size;
    longint cnt[3];
    result_t pending[$];
    int errors;
    int checked;

    function void reset_state();
      for (int a = 0; a < 3; a++) begin
        lo[a] = 0;
        hi[a] = 65536;
        cnt[a] = 0;
      end
      size = 65536;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function longint eff_size();
      return size > 0 ? size : 1;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      longint d;
      case (idx)
        REG_MIN_X: lo[0] = longint'($signed(data));
        REG_MIN_Y: lo[1] = longint'($signed(data));
        REG_MIN_Z: lo[2] = longint'($signed(data));
        REG_MAX_X: hi[0] = longint'($signed(data));
        REG_MAX_Y: hi[1] = longint'($signed(data));
        REG_MAX_Z: hi[2] = longint'($signed(data));
        REG_CELL_SIZE: size = longint'(data[SIZE_W-1:0]);
        default: return;
      endcase
      for (int a = 0; a < 3; a++) begin
        d = hi[a] - lo[a];
        if (d <= 0) cnt[a] = 0;
        else begin
          cnt[a] = d / eff_size();
          if (cnt[a] > MAX_CELLS_PER_AXIS) cnt[a] = MAX_CELLS_PER_AXIS;
        end
      end
    endfunction

    function longint cell_of(longint p, longint l);
      longint rel;
      longint q;
      rel = p - l;
      q = rel / eff_size();
      if (rel < 0 && rel % eff_size() != 0) q = q - 1;
      return q;
    endfunction

    function logic [OFS_W-1:0] scaled(longint c);
      longint v;
      v = c * eff_size();
      return v > longint'(OFS_SAT) ? OFS_SAT : v[OFS_W-1:0];
    endfunction

    function result_t locate(in_item_t it);
      result_t r;
      longint p[3];
      longint c[3];
      longint q, layer, rem, x, y, z;
      logic ok, ins;
      r = '0;
      if (it.mode == MODE_POS) begin
        p[0] = longint'(it.pos_x);
        p[1] = longint'(it.pos_y);
        p[2] = longint'(it.pos_z);
        ok = 1'b1;
        ins = 1'b1;
        for (int a = 0; a < 3; a++) begin
          c[a] = cell_of(p[a], lo[a]);
          if (c[a] < 0 || c[a] >= cnt[a]) ok = 1'b0;
          if (!(lo[a] < p[a] && p[a] < hi[a])) ins = 1'b0;
        end
        if (ok) r.cell_index = IDX_W'(c[0] + cnt[0] * c[1] + cnt[0] * cnt[1] * c[2]);
        r.inside_range = ins;
        r.in_grid = ok;
      end else begin
        q = longint'(it.query_index);
        layer = cnt[0] * cnt[1];
        x = 0;
        y = 0;
        z = 0;
        if (layer != 0) begin
          z = q / layer;
          rem = q - z * layer;
          y = rem / cnt[0];
          x = rem - y * cnt[0];
        end
        r.in_grid = q < layer * cnt[2];
        r.offset_x = scaled(x);
        r.offset_y = scaled(y);
        r.offset_z = scaled(z);
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      pending.push_back(locate(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.cell_index !== want.cell_index || got.inside_range !== want.inside_range ||
          got.in_grid !== want.in_grid || got.offset_x !== want.offset_x ||
          got.offset_y !== want.offset_y || got.offset_z !== want.offset_z) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t item;
  logic done;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grid_scoreboard sb;
  int cycles;
  int sent;
  int n_writes;
  bit quiet;

  uniform_grid_cell_index uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_input(item);
      if (done) sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sent++;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, longint data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data[CFG_DATA_W-1:0]);
    n_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(longint mn[3], longint mx[3], longint sz);
    wait_idle();
    write_reg(REG_MIN_X, mn[0]);
    write_reg(REG_MIN_Y, mn[1]);
    write_reg(REG_MIN_Z, mn[2]);
    write_reg(REG_MAX_X, mx[0]);
    write_reg(REG_MAX_Y, mx[1]);
    write_reg(REG_MAX_Z, mx[2]);
    write_reg(REG_CELL_SIZE, sz);
  endtask

  function automatic in_item_t pos_item(longint x, longint y, longint z);
    in_item_t it;
    it = '0;
    it.mode = MODE_POS;
    it.pos_x = x[POS_W-1:0];
    it.pos_y = y[POS_W-1:0];
    it.pos_z = z[POS_W-1:0];
    it.query_index = IDX_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t idx_item(longint q);
    in_item_t it;
    it = '0;
    it.mode = MODE_INDEX;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.query_index = q[IDX_W-1:0];
    return it;
  endfunction

  function automatic longint near_axis(int a);
    return sb.lo[a] + longint'($urandom_range(0, 200)) * sb.eff_size() / 10
      - sb.eff_size() + longint'($urandom_range(0, 3)) - 1;
  endfunction

  task automatic directed_items();
    longint tot;
    tot = sb.cnt[0] * sb.cnt[1] * sb.cnt[2];
    send_item(pos_item(sb.lo[0], sb.lo[1], sb.lo[2]));
    send_item(pos_item(sb.lo[0] + 1, sb.lo[1] + 1, sb.lo[2] + 1));
    send_item(pos_item(sb.hi[0] - 1, sb.hi[1] - 1, sb.hi[2] - 1));
    send_item(pos_item(sb.hi[0], sb.hi[1], sb.hi[2]));
    send_item(pos_item(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
    send_item(pos_item(64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
    send_item(idx_item(0));
    send_item(idx_item(tot - 1));
    send_item(idx_item(tot));
    send_item(idx_item(longint'(1 << IDX_W) - 1));
  endtask

  task automatic random_grid();
    longint mn[3];
    longint mx[3];
    longint sz;
    sz = $urandom_range(1, 3) == 1 ? longint'($urandom_range(1, 40))
                                   : longint'($urandom_range(256, 300000));
    for (int a = 0; a < 3; a++) begin
      mn[a] = longint'($signed($urandom)) >>> 2;
      mx[a] = mn[a] + sz * $urandom_range(0, 12) + $urandom_range(0, sz - 1);
    end
    set_grid(mn, mx, sz);
  endtask

  task automatic random_item();
    int pick;
    longint tot;
    in_item_t it;
    pick = $urandom_range(0, 99);
    tot = sb.cnt[0] * sb.cnt[1] * sb.cnt[2];
    if (pick < 45) begin
      send_item(pos_item(near_axis(0), near_axis(1), near_axis(2)));
    end else if (pick < 80) begin
      send_item(idx_item($urandom_range(0, tot + 3)));
    end else begin
      it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom});
      send_item(it);
    end
  endtask

  initial begin
    longint mn[3];
    longint mx[3];
    sb = new();
    sb.reset_state();
    cycles = 0;
    sent = 0;
    n_writes = 0;
    quiet = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_X;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Counts start at zero after reset, so nothing is in the grid yet.
    directed_items();

    mn = '{0, -262144, 131072};
    mx = '{4 * 65536, 65536, 131072 + 3 * 65536 + 100};
    set_grid(mn, mx, 65536);
    directed_items();

    mn = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
    mx = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
    set_grid(mn, mx, 0);
    directed_items();
    wait_idle();
    write_reg(REG_CELL_SIZE, 64'h7FFF_FFFF);
    directed_items();
    wait_idle();
    write_reg(REG_CELL_SIZE, 64'hFFFF_FFFF);
    write_reg(REG_UNUSED, 64'h1234_5678);
    directed_items();

    // Empty x and y axes: max at or below min.
    mn = '{1000, 5000, -7};
    mx = '{1000, 4000, 9000};
    set_grid(mn, mx, 3);
    directed_items();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 60 == 0) random_grid();
      quiet = (n >= 200 && n < 300);
      random_item();
    end

    wait_idle();
    if (sb.pending.size() != 0) sb.errors += sb.pending.size();
    $display("Sent %0d items and checked %0d results over %0d register writes,",
             sent, sb.checked, n_writes);
    $display("covering reset counts, saturated and empty axes and random grids.");
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
